// ===== src/cartridge_bank_controller_top_macros.svh =====
// ----------------------------------------------------------------------------
// Cartridge bank controller assertion macros
// Concurrent assertion wrappers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CARTRIDGE_BANK_CONTROLLER_TOP_MACROS_SVH
`define CARTRIDGE_BANK_CONTROLLER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Check a property at every clock edge outside reset.
`define CBC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("cartridge bank controller assertion failed");
// Check an implication that starts in one cycle and ends in the next.
`define CBC_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("cartridge bank controller assertion failed");
`else
`define CBC_ASSERT(lbl, prop)
`define CBC_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// ===== src/cbc_pkg.sv =====
// ----------------------------------------------------------------------------
// Cartridge bank controller package
// Widths, register indexes, controller and target codes, result record.
// ----------------------------------------------------------------------------
package cbc_pkg;

  localparam int ROM_BANK_WIDTH = 9;
  localparam int RAM_BANK_WIDTH = 4;
  localparam int ADDR_W         = 16;
  localparam int DATA_W         = 8;
  localparam int PHYS_W         = 23;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 5;
  localparam int CLOCK_REGS     = 5;
  localparam int CLOCK_IDX_W    = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CTRL_TYPE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_BITS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_BANKS  = 2'd2;

  // Controller types; every other code acts as rom only
  localparam logic [2:0] CT_ROM_ONLY = 3'd0;
  localparam logic [2:0] CT_MBC1     = 3'd1;
  localparam logic [2:0] CT_MBC2     = 3'd2;
  localparam logic [2:0] CT_MBC3     = 3'd3;
  localparam logic [2:0] CT_MBC5     = 3'd5;

  // Result targets
  localparam logic [2:0] TGT_NONE    = 3'd0;
  localparam logic [2:0] TGT_ROM     = 3'd1;
  localparam logic [2:0] TGT_RAM     = 3'd2;
  localparam logic [2:0] TGT_RTC     = 3'd3;
  localparam logic [2:0] TGT_NIBBLE  = 3'd4;
  localparam logic [2:0] TGT_NONCART = 3'd5;

  localparam logic [3:0] RAM_EN_KEY  = 4'hA;
  localparam logic [3:0] CLK_SEL_LO  = 4'h8;
  localparam logic [3:0] CLK_SEL_HI  = 4'hC;
  localparam logic [DATA_W-1:0] OPEN_BUS    = 8'hFF;
  localparam logic [DATA_W-1:0] NIBBLE_MASK = 8'hF0;

  typedef struct packed {
    logic [2:0]        target;
    logic [PHYS_W-1:0] phys_addr;
    logic              mem_write;
    logic [DATA_W-1:0] mem_wdata;
    logic [DATA_W-1:0] read_value;
    logic [DATA_W-1:0] or_mask;
  } cbc_result_t;

  // Bank mask from the log2 bank count, saturated to 1..ROM_BANK_WIDTH.
  function automatic logic [ROM_BANK_WIDTH-1:0] rom_mask(input logic [3:0] bits);
    logic [3:0]                sat;
    logic [ROM_BANK_WIDTH-1:0] mask;
    sat = bits;
    if (sat == 4'd0) sat = 4'd1;
    if (sat > 4'(ROM_BANK_WIDTH)) sat = 4'(ROM_BANK_WIDTH);
    for (int i = 0; i < ROM_BANK_WIDTH; i++) begin
      mask[i] = (4'(i) < sat);
    end
    return mask;
  endfunction

endpackage

// ===== src/cartridge_bank_controller_top.sv =====
// ----------------------------------------------------------------------------
// Cartridge bank controller
// Maps CPU bus accesses onto cartridge ROM, external RAM and clock registers.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i / in_ready_o) carries one bus access item:
//    kind_i (0 read, 1 write), address_i and wdata_i.
//  - Output channel (out_valid_o / out_ready_i) returns exactly one result
//    item per access: target, physical address, write strobe and data,
//    read value for open bus or clock reads, and the read OR mask.
//  - Configuration channel (cfg_valid_i / cfg_ready_o) writes controller
//    type, ROM bank bits and RAM bank count; it is always ready. Write it
//    only while no access is in flight.
//  - The result sits in the output register on the cycle after the access is
//    taken. Throughput is one access per cycle while the receiver does not
//    stall, set by the single mapping stage between the input port and the
//    output register; bank registers update at the same edge, so the next
//    access already sees them.
//  - When the receiver stalls, the output register holds its item and the
//    input is taken only in the cycle that item leaves.
//  - Reset clears the bank registers (ROM bank 1), the clock bytes and the
//    configuration (rom only, one ROM bank bit, no RAM); the output is empty.
// ----------------------------------------------------------------------------
`include "cartridge_bank_controller_top_macros.svh"

module cartridge_bank_controller_top import cbc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Access input
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  kind_i,
  input  logic [ADDR_W-1:0]     address_i,
  input  logic [DATA_W-1:0]     wdata_i,
  // Result output
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [2:0]            target_o,
  output logic [PHYS_W-1:0]     phys_addr_o,
  output logic                  mem_write_o,
  output logic [DATA_W-1:0]     mem_wdata_o,
  output logic [DATA_W-1:0]     read_value_o,
  output logic [DATA_W-1:0]     or_mask_o
);

  // Configuration registers
  logic [2:0] ctrl_type_q;
  logic [3:0] rom_bits_q;
  logic [4:0] ram_banks_q;

  // Bank controller state
  logic [ROM_BANK_WIDTH-1:0] rom_sel_q, rom_sel_d;
  logic [1:0]                upper_bits_q, upper_bits_d;
  logic [RAM_BANK_WIDTH-1:0] ram_bank_sel_q, ram_bank_sel_d;
  logic                      ram_on_q, ram_on_d;
  logic                      bank_mode_q, bank_mode_d;
  logic [3:0]                clock_sel_q, clock_sel_d;
  logic [DATA_W-1:0]         clock_regs_q [CLOCK_REGS];

  logic                   clk_we;
  logic [CLOCK_IDX_W-1:0] clk_idx;

  logic        out_valid_q;
  cbc_result_t res_q, res_d;
  logic        in_fire;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;

  always_comb begin
    logic [ROM_BANK_WIDTH-1:0] mask;
    logic [ROM_BANK_WIDTH-1:0] win_bank;
    logic [RAM_BANK_WIDTH-1:0] ram_bank;
    logic [3:0]                region;
    logic                      en;
    logic                      clk_sel_ok;

    mask       = rom_mask(rom_bits_q);
    region     = address_i[15:12];
    en         = (wdata_i[3:0] == RAM_EN_KEY);
    clk_sel_ok = (clock_sel_q >= CLK_SEL_LO) && (clock_sel_q <= CLK_SEL_HI);
    win_bank   = '0;
    ram_bank   = '0;

    rom_sel_d      = rom_sel_q;
    upper_bits_d   = upper_bits_q;
    ram_bank_sel_d = ram_bank_sel_q;
    ram_on_d       = ram_on_q;
    bank_mode_d    = bank_mode_q;
    clock_sel_d    = clock_sel_q;
    clk_we         = 1'b0;
    clk_idx        = CLOCK_IDX_W'(clock_sel_q - CLK_SEL_LO);

    res_d = '0;

    if (!address_i[15]) begin
      if (kind_i) begin
        // Register write: no memory access, result stays all zero
        case (ctrl_type_q)
          CT_MBC1: begin
            if (region <= 4'd1) begin
              ram_on_d = en;
            end else if (region <= 4'd3) begin
              rom_sel_d = (wdata_i[4:0] == 5'd0) ? ROM_BANK_WIDTH'(1)
                                                  : ROM_BANK_WIDTH'(wdata_i[4:0]);
            end else if (region <= 4'd5) begin
              upper_bits_d = wdata_i[1:0];
            end else begin
              bank_mode_d = wdata_i[0];
            end
          end
          CT_MBC2: begin
            if (region <= 4'd3) begin
              if (!address_i[8]) begin
                ram_on_d = en;
              end else begin
                rom_sel_d = (wdata_i[3:0] == 4'd0) ? ROM_BANK_WIDTH'(1)
                                                    : ROM_BANK_WIDTH'(wdata_i[3:0]);
              end
            end
          end
          CT_MBC3: begin
            if (region <= 4'd1) begin
              ram_on_d = en;
            end else if (region <= 4'd3) begin
              rom_sel_d = (wdata_i[6:0] == 7'd0) ? ROM_BANK_WIDTH'(1)
                                                  : ROM_BANK_WIDTH'(wdata_i[6:0]);
            end else if (region <= 4'd5) begin
              if (wdata_i <= 8'd3) begin
                if (ram_banks_q >= 5'd4) ram_bank_sel_d = RAM_BANK_WIDTH'(wdata_i[1:0]);
                clock_sel_d = 4'd0;
              end else if (wdata_i >= 8'(CLK_SEL_LO) && wdata_i <= 8'(CLK_SEL_HI)) begin
                clock_sel_d = wdata_i[3:0];
              end
            end
          end
          CT_MBC5: begin
            if (region <= 4'd1) begin
              ram_on_d = en;
            end else if (region == 4'd2) begin
              rom_sel_d = {rom_sel_q[8], wdata_i};
            end else if (region == 4'd3) begin
              upper_bits_d = {1'b0, wdata_i[0]};
              rom_sel_d    = {wdata_i[0], rom_sel_q[7:0]};
            end else if (region <= 4'd5) begin
              if (ram_banks_q >= {1'b0, wdata_i[3:0]}) begin
                ram_bank_sel_d = RAM_BANK_WIDTH'(wdata_i[3:0]);
              end
            end
          end
          default: begin
            // rom only: drop register writes
          end
        endcase
      end else begin
        if (!address_i[14]) begin
          win_bank = (ctrl_type_q == CT_MBC1 && bank_mode_q)
                   ? (ROM_BANK_WIDTH'({upper_bits_q, 5'd0}) & mask) : '0;
        end else if (ctrl_type_q == CT_MBC1) begin
          win_bank = ROM_BANK_WIDTH'({upper_bits_q, rom_sel_q[4:0]}) & mask;
        end else if (ctrl_type_q == CT_MBC2 || ctrl_type_q == CT_MBC3 ||
                     ctrl_type_q == CT_MBC5) begin
          win_bank = rom_sel_q & mask;
        end else begin
          win_bank = ROM_BANK_WIDTH'(1) & mask;
        end
        res_d.target    = TGT_ROM;
        res_d.phys_addr = PHYS_W'({win_bank, address_i[13:0]});
      end
    end else if (address_i[15:13] == 3'b101) begin
      if (!ram_on_q) begin
        res_d.read_value = kind_i ? '0 : OPEN_BUS;
      end else if (ctrl_type_q == CT_MBC2) begin
        res_d.target    = TGT_NIBBLE;
        res_d.phys_addr = PHYS_W'(address_i[8:0]);
        if (kind_i) begin
          res_d.mem_write = 1'b1;
          res_d.mem_wdata = {4'd0, wdata_i[3:0]};
        end else begin
          res_d.or_mask = NIBBLE_MASK;
        end
      end else if (ctrl_type_q == CT_MBC3 && clk_sel_ok) begin
        res_d.target = TGT_RTC;
        if (kind_i) clk_we = 1'b1;
        else        res_d.read_value = clock_regs_q[clk_idx];
      end else begin
        ram_bank = (ctrl_type_q == CT_MBC1)
                 ? (bank_mode_q ? RAM_BANK_WIDTH'(upper_bits_q) : '0)
                 : ram_bank_sel_q;
        if (5'(ram_bank) >= ram_banks_q) begin
          res_d.read_value = kind_i ? '0 : OPEN_BUS;
        end else begin
          res_d.target    = TGT_RAM;
          res_d.phys_addr = PHYS_W'({ram_bank, address_i[12:0]});
          if (kind_i) begin
            res_d.mem_write = 1'b1;
            res_d.mem_wdata = wdata_i;
          end
        end
      end
    end else begin
      // Not a cartridge address: pass it through
      res_d.target    = TGT_NONCART;
      res_d.phys_addr = PHYS_W'(address_i);
      if (kind_i) begin
        res_d.mem_write = 1'b1;
        res_d.mem_wdata = wdata_i;
      end
    end
  end

  // Configuration and bank state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_type_q    <= CT_ROM_ONLY;
      rom_bits_q     <= 4'd1;
      ram_banks_q    <= 5'd0;
      rom_sel_q      <= ROM_BANK_WIDTH'(1);
      upper_bits_q   <= '0;
      ram_bank_sel_q <= '0;
      ram_on_q       <= 1'b0;
      bank_mode_q    <= 1'b0;
      clock_sel_q    <= '0;
      for (int i = 0; i < CLOCK_REGS; i++) clock_regs_q[i] <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_CTRL_TYPE: ctrl_type_q <= cfg_data_i[2:0];
          CFG_ROM_BITS:  rom_bits_q  <= cfg_data_i[3:0];
          CFG_RAM_BANKS: ram_banks_q <= cfg_data_i;
          default: begin
            // unknown index: ignore
          end
        endcase
      end
      if (in_fire) begin
        rom_sel_q      <= rom_sel_d;
        upper_bits_q   <= upper_bits_d;
        ram_bank_sel_q <= ram_bank_sel_d;
        ram_on_q       <= ram_on_d;
        bank_mode_q    <= bank_mode_d;
        clock_sel_q    <= clock_sel_d;
        if (clk_we) clock_regs_q[clk_idx] <= wdata_i;
      end
    end
  end

  // Output register: advance on accept, hold while the receiver stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) res_q <= res_d;
  end

  assign out_valid_o  = out_valid_q;
  assign target_o     = res_q.target;
  assign phys_addr_o  = res_q.phys_addr;
  assign mem_write_o  = res_q.mem_write;
  assign mem_wdata_o  = res_q.mem_wdata;
  assign read_value_o = res_q.read_value;
  assign or_mask_o    = res_q.or_mask;

  `CBC_ASSERT(a_clock_sel_legal,
              clock_sel_q == 4'd0 || (clock_sel_q >= CLK_SEL_LO && clock_sel_q <= CLK_SEL_HI))
  `CBC_ASSERT(a_write_target,
              !out_valid_q || !res_q.mem_write || res_q.target == TGT_RAM ||
              res_q.target == TGT_NIBBLE || res_q.target == TGT_NONCART)
  `CBC_ASSERT(a_or_mask_nibble,
              !out_valid_q || res_q.or_mask == '0 || res_q.target == TGT_NIBBLE)
  `CBC_ASSERT_NEXT(a_result_kept, out_valid_q && !out_ready_i, out_valid_q)

endmodule

// ===== verif/tb_cartridge_bank_controller_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cartridge bank controller testbench
// Drives CPU bus accesses through a series of controller settings, predicts
// each mapped result in a shadow bank controller and checks every result
// field against it, with random idling and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_cartridge_bank_controller_top;
  import cbc_pkg::*;

  // Access kinds on the input channel
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // Controller codes with no package name; all of them act as rom only
  localparam logic [2:0] CT_MMM01  = 3'd4;
  localparam logic [2:0] CT_SPARE6 = 3'd6;
  localparam logic [2:0] CT_SPARE7 = 3'd7;

  localparam int NUM_PHASES       = 16;
  localparam int ACCESSES_PER_SET = 95;
  localparam int SETTLE_CYCLES    = 4;      // margin after the last result
  localparam int HOLDOFF_CYCLES   = 150;    // long receiver stall
  localparam int CYCLE_LIMIT      = 200000;
  localparam int REPORT_LIMIT     = 10;

  typedef struct {
    logic        kind;
    logic [15:0] addr;
    logic [7:0]  data;
    bit          drain_first;  // wait for every result before offering this item
  } bus_access_t;

  // --------------------------------------------------------------------------
  // DUT ports; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic                  kind_i      = KIND_READ;
  logic [ADDR_W-1:0]     address_i   = '0;
  logic [DATA_W-1:0]     wdata_i     = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [2:0]            target_o;
  logic [PHYS_W-1:0]     phys_addr_o;
  logic                  mem_write_o;
  logic [DATA_W-1:0]     mem_wdata_o;
  logic [DATA_W-1:0]     read_value_o;
  logic [DATA_W-1:0]     or_mask_o;

  cartridge_bank_controller_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .address_i   (address_i),
    .wdata_i     (wdata_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .target_o    (target_o),
    .phys_addr_o (phys_addr_o),
    .mem_write_o (mem_write_o),
    .mem_wdata_o (mem_wdata_o),
    .read_value_o(read_value_o),
    .or_mask_o   (or_mask_o)
  );

  // --------------------------------------------------------------------------
  // Shadow bank controller: configuration and bank registers at reset values
  // --------------------------------------------------------------------------
  logic [2:0]                ctl_type   = CT_ROM_ONLY;
  logic [3:0]                rom_bits   = 4'd1;
  logic [4:0]                ram_count  = 5'd0;
  logic [ROM_BANK_WIDTH-1:0] rom_sel    = 9'd1;
  logic [1:0]                upper_sel  = 2'd0;
  logic [RAM_BANK_WIDTH-1:0] ram_sel    = 4'd0;
  logic                      ram_en     = 1'b0;
  logic                      mode_sel   = 1'b0;
  logic [3:0]                clk_sel    = 4'd0;
  logic [7:0]                clock_bytes [CLOCK_REGS] = '{default: 8'h00};

  // Testbench bookkeeping
  bus_access_t access_q[$];      // items waiting to be offered
  cbc_result_t mapped_q[$];      // predicted results, oldest first
  bus_access_t next_access;
  bit          access_taken   = 1'b0;
  bit          calm           = 1'b0;  // no idling on either side
  int          stall_requests = 0;
  int          stall_served   = 0;
  int          stall_left     = 0;
  int          error_count    = 0;
  int          checked_count  = 0;
  int          accepted_count = 0;
  int          cycle_count    = 0;
  int          target_seen [6] = '{default: 0};

  // Phase settings: controller type, log2 ROM banks, RAM bank count
  logic [2:0] set_type [NUM_PHASES] = '{CT_ROM_ONLY, CT_MBC1, CT_MBC2, CT_MBC3,
                                        CT_MBC5, CT_MBC5, CT_MBC1, CT_MBC3,
                                        CT_MMM01, CT_SPARE6, CT_SPARE7, CT_MBC1,
                                        CT_MBC2, CT_MBC3, CT_ROM_ONLY, CT_ROM_ONLY};
  logic [3:0] set_bits [NUM_PHASES] = '{4'd1, 4'd7, 4'd4, 4'd7, 4'd9, 4'd1, 4'd1, 4'd15,
                                        4'd0, 4'd5, 4'd8, 4'd9, 4'd9, 4'd9, 4'd1, 4'd1};
  logic [4:0] set_ram  [NUM_PHASES] = '{5'd0, 5'd4, 5'd0, 5'd4, 5'd16, 5'd0, 5'd1, 5'd3,
                                        5'd31, 5'd2, 5'd16, 5'd4, 5'd16, 5'd16, 5'd0, 5'd0};

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // ROM bank mask: saturate the log2 count to 1..ROM_BANK_WIDTH.
  function automatic logic [ROM_BANK_WIDTH-1:0] rom_win_mask();
    int b;
    b = rom_bits;
    if (b < 1) b = 1;
    if (b > ROM_BANK_WIDTH) b = ROM_BANK_WIDTH;
    return ROM_BANK_WIDTH'((1 << b) - 1);
  endfunction

  // Register write below 0x8000 for the current controller type.
  function automatic void update_bank_regs(logic [15:0] a, logic [7:0] d);
    logic [3:0] region;
    logic       en;
    region = a[15:12];
    en     = (d[3:0] == RAM_EN_KEY);
    case (ctl_type)
      CT_MBC1: begin
        if (region <= 1) ram_en = en;
        else if (region <= 3) rom_sel = (d[4:0] == 0) ? 9'd1 : 9'(d[4:0]);
        else if (region <= 5) upper_sel = d[1:0];
        else mode_sel = d[0];
      end
      CT_MBC2: begin
        if (region <= 3) begin
          if (!a[8]) ram_en = en;
          else rom_sel = (d[3:0] == 0) ? 9'd1 : 9'(d[3:0]);
        end
      end
      CT_MBC3: begin
        if (region <= 1) ram_en = en;
        else if (region <= 3) rom_sel = (d[6:0] == 0) ? 9'd1 : 9'(d[6:0]);
        else if (region <= 5) begin
          if (d <= 8'd3) begin
            if (ram_count >= 5'd4) ram_sel = 4'(d[1:0]);
            clk_sel = 4'd0;
          end else if (d >= 8'(CLK_SEL_LO) && d <= 8'(CLK_SEL_HI)) begin
            clk_sel = d[3:0];
          end
        end
      end
      CT_MBC5: begin
        if (region <= 1) ram_en = en;
        else if (region == 2) rom_sel = {rom_sel[8], d};
        else if (region == 3) begin
          upper_sel = {1'b0, d[0]};
          rom_sel   = {d[0], rom_sel[7:0]};
        end else if (region <= 5) begin
          if (ram_count >= 5'(d[3:0])) ram_sel = d[3:0];
        end
      end
      default: ;  // rom only and its aliases ignore register writes
    endcase
  endfunction

  // Map one accepted access and advance the shadow registers.
  function automatic cbc_result_t map_access(logic wr, logic [15:0] a, logic [7:0] d);
    cbc_result_t               r;
    logic [ROM_BANK_WIDTH-1:0] mask;
    logic [ROM_BANK_WIDTH-1:0] win_bank;
    logic [RAM_BANK_WIDTH-1:0] ram_bank;
    int                        idx;
    r    = '0;
    mask = rom_win_mask();
    if (a < 16'h8000) begin
      if (wr) begin
        update_bank_regs(a, d);
      end else begin
        if (a < 16'h4000)
          win_bank = (ctl_type == CT_MBC1 && mode_sel) ? (9'({upper_sel, 5'd0}) & mask) : '0;
        else if (ctl_type == CT_MBC1)
          win_bank = 9'({upper_sel, rom_sel[4:0]}) & mask;
        else if (ctl_type == CT_MBC2 || ctl_type == CT_MBC3 || ctl_type == CT_MBC5)
          win_bank = rom_sel & mask;
        else
          win_bank = 9'd1 & mask;
        r.target    = TGT_ROM;
        r.phys_addr = {win_bank, a[13:0]};
      end
    end else if (a >= 16'hA000 && a < 16'hC000) begin
      if (!ram_en) begin
        r.read_value = wr ? 8'h00 : OPEN_BUS;
      end else if (ctl_type == CT_MBC2) begin
        r.target    = TGT_NIBBLE;
        r.phys_addr = 23'(a[8:0]);
        if (wr) begin
          r.mem_write = 1'b1;
          r.mem_wdata = {4'h0, d[3:0]};
        end else begin
          r.or_mask = NIBBLE_MASK;
        end
      end else if (ctl_type == CT_MBC3 && clk_sel >= CLK_SEL_LO && clk_sel <= CLK_SEL_HI) begin
        idx      = clk_sel - CLK_SEL_LO;
        r.target = TGT_RTC;
        if (wr) clock_bytes[idx] = d;
        else r.read_value = clock_bytes[idx];
      end else begin
        if (ctl_type == CT_MBC1) ram_bank = mode_sel ? 4'(upper_sel) : 4'd0;
        else ram_bank = ram_sel;
        if (5'(ram_bank) >= ram_count) begin
          r.read_value = wr ? 8'h00 : OPEN_BUS;
        end else begin
          r.target    = TGT_RAM;
          r.phys_addr = 23'({ram_bank, a[12:0]});
          if (wr) begin
            r.mem_write = 1'b1;
            r.mem_wdata = d;
          end
        end
      end
    end else begin
      r.target    = TGT_NONCART;
      r.phys_addr = 23'(a);
      if (wr) begin
        r.mem_write = 1'b1;
        r.mem_wdata = d;
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void push_access(logic kind, logic [15:0] addr, logic [7:0] data);
    bus_access_t it;
    it.kind        = kind;
    it.addr        = addr;
    it.data        = data;
    it.drain_first = 1'b0;
    access_q.push_back(it);
  endfunction

  // Mostly meaningful traffic: ROM reads, decoded register writes with useful
  // values, RAM window traffic, off-cartridge accesses and window boundaries.
  function automatic bus_access_t random_access();
    bus_access_t it;
    int          pick;
    logic [15:0] boundary [12];
    boundary = '{16'h0000, 16'h3FFF, 16'h4000, 16'h7FFF, 16'h8000, 16'h9FFF,
                 16'hA000, 16'hBFFF, 16'hC000, 16'hFFFF, 16'h0100, 16'h2100};
    pick           = $urandom_range(99);
    it.kind        = 1'($urandom_range(1));
    it.data        = 8'($urandom_range(255));
    it.drain_first = ($urandom_range(149) == 0);
    if (pick < 30) begin
      it.kind = KIND_READ;
      it.addr = 16'($urandom_range(16'h7FFF));
    end else if (pick < 55) begin
      it.kind = KIND_WRITE;
      it.addr = 16'($urandom_range(16'h7FFF));
      case ($urandom_range(4))
        0: it.data = {4'($urandom_range(15)), RAM_EN_KEY};
        1: it.data = 8'($urandom_range(3));
        2: it.data = 8'($urandom_range(CLK_SEL_HI, CLK_SEL_LO));
        3: it.data = 8'($urandom_range(31));
        default: ;
      endcase
    end else if (pick < 85) begin
      it.addr = 16'($urandom_range(16'hBFFF, 16'hA000));
    end else if (pick < 93) begin
      it.addr = $urandom_range(1) ? 16'($urandom_range(16'h9FFF, 16'h8000))
                                  : 16'($urandom_range(16'hFFFF, 16'hC000));
    end else begin
      it.addr = boundary[$urandom_range(11)];
    end
    return it;
  endfunction

  // Write one configuration register; the valid stays up for a following write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_CTRL_TYPE: ctl_type  = val[2:0];
      CFG_ROM_BITS:  rom_bits  = val[3:0];
      CFG_RAM_BANKS: ram_count = val;
      default: ;
    endcase
  endtask

  task automatic apply_setting(logic [2:0] t, logic [3:0] b, logic [4:0] c);
    write_reg(CFG_CTRL_TYPE, 5'(t));
    write_reg(CFG_ROM_BITS, 5'(b));
    write_reg(CFG_RAM_BANKS, c);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Hold until every queued item is taken and every result has come back,
  // then let the pipeline settle.
  task automatic wait_drained();
    while (access_q.size() != 0 || in_valid_i || mapped_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Clock, reset and watchdog
  // --------------------------------------------------------------------------
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still outstanding",
               cycle_count, mapped_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Access driver: change inputs on the falling edge, hold until accepted
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !access_taken) begin
      // hold the offered item and its payload
    end else if (access_q.size() != 0 && (calm || $urandom_range(99) >= 8) &&
                 !(access_q[0].drain_first && mapped_q.size() != 0)) begin
      next_access = access_q.pop_front();
      in_valid_i <= 1'b1;
      kind_i     <= next_access.kind;
      address_i  <= next_access.addr;
      wdata_i    <= next_access.data;
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver: random back-pressure plus requested long hold-offs
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (stall_served != stall_requests) begin
      stall_served = stall_requests;
      stall_left   = HOLDOFF_CYCLES;
      out_ready_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm || ($urandom_range(99) >= 8);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check returned results first, then record newly taken accesses
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    cbc_result_t want;
    cbc_result_t got;
    access_taken = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = {target_o, phys_addr_o, mem_write_o, mem_wdata_o, read_value_o, or_mask_o};
        if (got.target < 6) target_seen[got.target]++;
        if (mapped_q.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("%0t: result with nothing outstanding: tgt=%0d phys=%h", $time,
                     got.target, got.phys_addr);
        end else begin
          want = mapped_q.pop_front();
          checked_count++;
          if (got.target !== want.target || got.phys_addr !== want.phys_addr ||
              got.mem_write !== want.mem_write || got.mem_wdata !== want.mem_wdata ||
              got.read_value !== want.read_value || got.or_mask !== want.or_mask) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
              $display("%0t: mismatch exp tgt=%0d phys=%h wr=%b wd=%h rv=%h om=%h", $time,
                       want.target, want.phys_addr, want.mem_write, want.mem_wdata,
                       want.read_value, want.or_mask);
              $display("%0t:          got tgt=%0d phys=%h wr=%b wd=%h rv=%h om=%h", $time,
                       got.target, got.phys_addr, got.mem_write, got.mem_wdata,
                       got.read_value, got.or_mask);
            end
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        mapped_q.push_back(map_access(kind_i, address_i, wdata_i));
        access_taken = 1'b1;
        accepted_count++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: reset, then one phase per controller setting
  // --------------------------------------------------------------------------
  initial begin : sequencer
    logic [2:0] t;
    logic [3:0] b;
    logic [4:0] c;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int p = 0; p < NUM_PHASES; p++) begin
      t = set_type[p];
      b = set_bits[p];
      c = set_ram[p];
      // last phases pick any setting the register widths allow
      if (p >= NUM_PHASES - 2) begin
        t = 3'($urandom_range(7));
        b = 4'($urandom_range(15));
        c = 5'($urandom_range(31));
      end
      // first phase runs on the reset configuration
      if (p != 0) apply_setting(t, b, c);
      calm = (p == 9 || p == 10);

      case (p)
        0: begin
          // rom only: fixed upper window, register writes dropped
          push_access(KIND_READ,  16'h4000, 8'h00);
          push_access(KIND_WRITE, 16'h2000, 8'h05);
        end
        1: begin
          // MBC1: bank zero alias, upper bits, both banking modes, RAM on/off
          push_access(KIND_WRITE, 16'h0000, {4'h0, RAM_EN_KEY});
          push_access(KIND_WRITE, 16'h2000, 8'h00);
          push_access(KIND_READ,  16'h4000, 8'h00);
          push_access(KIND_WRITE, 16'h3FFF, 8'h1F);
          push_access(KIND_WRITE, 16'h4000, 8'h03);
          push_access(KIND_READ,  16'h7FFF, 8'h00);
          push_access(KIND_WRITE, 16'h6000, 8'h01);
          push_access(KIND_READ,  16'h0000, 8'h00);
          push_access(KIND_WRITE, 16'hBFFF, 8'hFF);
          push_access(KIND_WRITE, 16'h1FFF, 8'h00);
          push_access(KIND_READ,  16'hA000, 8'h00);
        end
        2: begin
          // MBC2: address bit 8 splits enable from bank select; nibble RAM
          push_access(KIND_WRITE, 16'h0000, {4'h0, RAM_EN_KEY});
          push_access(KIND_WRITE, 16'h3100, 8'h00);
          push_access(KIND_WRITE, 16'hBE00, 8'hFF);
          push_access(KIND_READ,  16'hA1FF, 8'h00);
        end
        3: begin
          // MBC3: clock register select, clock write and read, back to RAM
          push_access(KIND_WRITE, 16'h0000, {4'h0, RAM_EN_KEY});
          push_access(KIND_WRITE, 16'h5000, 8'(CLK_SEL_LO));
          push_access(KIND_WRITE, 16'hA000, 8'h5A);
          push_access(KIND_READ,  16'hA000, 8'h00);
          push_access(KIND_WRITE, 16'h4000, 8'h02);
          push_access(KIND_READ,  16'hA123, 8'h00);
        end
        4: begin
          // MBC5: full nine-bit bank, top RAM bank
          push_access(KIND_WRITE, 16'h2000, 8'hFF);
          push_access(KIND_WRITE, 16'h3000, 8'h01);
          push_access(KIND_READ,  16'h7FFF, 8'h00);
          push_access(KIND_WRITE, 16'h4000, 8'h0F);
          push_access(KIND_WRITE, 16'h0000, {4'h0, RAM_EN_KEY});
          push_access(KIND_WRITE, 16'hA000, 8'h77);
        end
        default: ;
      endcase

      repeat (ACCESSES_PER_SET) access_q.push_back(random_access());

      // stall the receiver while the sender keeps offering, fill the block
      if (p == 4) stall_requests++;
      // pause the sender until the block has emptied
      if (p == 6) access_q[ACCESSES_PER_SET / 2].drain_first = 1'b1;

      wait_drained();
    end

    $display("Covered %0d bus accesses over %0d bank controller settings, %0d results checked",
             accepted_count, NUM_PHASES, checked_count);
    $display("Targets: dropped %0d, rom %0d, ram %0d, clock %0d, nibble %0d, off-cart %0d",
             target_seen[0], target_seen[1], target_seen[2], target_seen[3],
             target_seen[4], target_seen[5]);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d failures", error_count);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== cartridge_bank_controller_top.f =====
+incdir+src
src/cbc_pkg.sv
src/cartridge_bank_controller_top.sv
verif/tb_cartridge_bank_controller_top.sv
